>>> rtl/cwc_pkg.sv
`timescale 1ns / 1ps
package cwc_pkg;
   localparam int CLASS_W = 32;
   localparam int DIM_W   = 11;
   localparam int CELL_W  = 20;
   localparam int CNT_W   = 21;
   localparam int STAT_W  = 2;
   localparam int IDX_W   = 2;

   localparam logic [IDX_W-1:0] REG_TARGET = 2'd0;
   localparam logic [IDX_W-1:0] REG_ROWS   = 2'd1;
   localparam logic [IDX_W-1:0] REG_COLS   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_HALF    = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOTABLE = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_LD_RD, S_LD_WR, S_DIV, S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_OUT
   } state_type;

   typedef struct packed {
      logic ld_start;   // latch load word, issue above read
      logic ld_diag;    // issue diag read
      logic ld_write;   // compute and write
      logic q_start;    // latch query, check status
      logic div_step;
      logic q_rd;       // issue corner read (index q_sel)
      logic [1:0] q_sel;
      logic q_acc;      // accumulate previous read
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic q_err;
      logic out_full;
   } sts_type;
endpackage

>>> rtl/cwc_if.sv
`timescale 1ns / 1ps
interface cwc_req_if;
   logic valid;
   logic ready;
   logic func;
   logic signed [cwc_pkg::CLASS_W-1:0] land_value;
   logic is_missing;
   logic [cwc_pkg::CELL_W-1:0] query_cell;
   logic [cwc_pkg::DIM_W-1:0] half_width_x;
   logic [cwc_pkg::DIM_W-1:0] half_width_y;
   modport source (output valid, func, land_value, is_missing, query_cell,
                   half_width_x, half_width_y, input ready);
   modport sink (input valid, func, land_value, is_missing, query_cell,
                 half_width_x, half_width_y, output ready);
endinterface

interface cwc_rsp_if;
   logic valid;
   logic ready;
   logic [cwc_pkg::CNT_W-1:0] window_count;
   logic [cwc_pkg::STAT_W-1:0] status;
   modport source (output valid, window_count, status, input ready);
   modport sink (input valid, window_count, status, output ready);
endinterface

>>> rtl/class_window_count_integral_image.sv
`timescale 1ns / 1ps
// Class window counter over a summed-area table.
// req channel: func 0 loads the next raster cell (row-major), func 1 asks a
// window count around query_cell with half-widths half_width_x/y.
// rsp channel: one word per query (window_count, status); loads give none.
// csr port: index 0 target_class, 1 row_count, 2 col_count; a write to
// one of these restarts loading, the table contents stay.
// A load takes two reads (above, diagonal) and one write on the
// single-port table memory. For a query, 20 restoring division steps
// split the cell index into row and column, then the window bounds are
// set, then four table reads are accumulated one per cycle.
// Errored queries go from the division state straight to the result.
// One item is in work at a time; req_ready is high only when idle.
// The result register holds a word while rsp_ready is low; the next
// query waits at its end until the register is free.
// Reset clears control state and the configuration, load and result-valid
// registers; the table memory is not cleared and queries read it only after a full load.
module class_window_count_integral_image #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 1024
) (
   input  logic clock,
   input  logic reset,
   cwc_req_if.sink req,
   cwc_rsp_if.source rsp,
   input  logic csr_write,
   input  logic [cwc_pkg::IDX_W-1:0] csr_index,
   input  logic [cwc_pkg::CLASS_W-1:0] csr_data
);
   cwc_pkg::cmd_type cmd;
   cwc_pkg::sts_type sts;

   cwc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_func(req.func),
      .req_ready(req.ready), .sts(sts), .cmd(cmd)
   );

   cwc_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_land_value(req.land_value),
      .req_is_missing(req.is_missing), .req_query_cell(req.query_cell),
      .req_half_width_x(req.half_width_x), .req_half_width_y(req.half_width_y),
      .cmd(cmd), .sts(sts), .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .rsp_window_count(rsp.window_count), .rsp_status(rsp.status)
   );
endmodule

>>> rtl/cwc_ctrl.sv
`timescale 1ns / 1ps
module cwc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_func,
   output logic req_ready,
   input  cwc_pkg::sts_type sts,
   output cwc_pkg::cmd_type cmd
);
   cwc_pkg::state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwc_pkg::S_IDLE;
         sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cmd = '0;
      cmd.q_sel = sel_ff;
      req_ready = 1'b0;
      case (state_ff)
         cwc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_func) begin
                  cmd.ld_start = 1'b1;
                  state_in = cwc_pkg::S_LD_RD;
               end else begin
                  cmd.q_start = 1'b1;
                  state_in = cwc_pkg::S_DIV;
               end
            end
         end
         cwc_pkg::S_LD_RD: begin
            cmd.ld_diag = 1'b1;
            state_in = cwc_pkg::S_LD_WR;
         end
         cwc_pkg::S_LD_WR: begin
            cmd.ld_write = 1'b1;
            state_in = cwc_pkg::S_IDLE;
         end
         cwc_pkg::S_DIV: begin
            if (sts.q_err) begin
               state_in = cwc_pkg::S_OUT;
            end else if (sts.div_done) begin
               // corner bounds latch in this cycle, reads start next
               sel_in = 2'd0;
               state_in = cwc_pkg::S_Q0;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         cwc_pkg::S_Q0, cwc_pkg::S_Q1, cwc_pkg::S_Q2, cwc_pkg::S_Q3: begin
            cmd.q_rd = 1'b1;
            cmd.q_acc = (state_ff != cwc_pkg::S_Q0);
            sel_in = sel_ff + 2'd1;
            state_in = (state_ff == cwc_pkg::S_Q0) ? cwc_pkg::S_Q1 :
                       (state_ff == cwc_pkg::S_Q1) ? cwc_pkg::S_Q2 :
                       (state_ff == cwc_pkg::S_Q2) ? cwc_pkg::S_Q3 : cwc_pkg::S_Q4;
         end
         cwc_pkg::S_Q4: begin
            cmd.q_acc = 1'b1;
            state_in = cwc_pkg::S_OUT;
         end
         cwc_pkg::S_OUT: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               state_in = cwc_pkg::S_IDLE;
            end
         end
         default: state_in = cwc_pkg::S_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == cwc_pkg::S_IDLE) else $error("ready outside idle");
   a_load_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_start |=> state_ff == cwc_pkg::S_LD_RD) else $error("load sequence");
   a_wr_after: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_write |-> $past(cmd.ld_diag)) else $error("write without reads");
endmodule

>>> rtl/cwc_datapath.sv
`timescale 1ns / 1ps
module cwc_datapath #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [cwc_pkg::IDX_W-1:0] csr_index,
   input  logic [cwc_pkg::CLASS_W-1:0] csr_data,
   input  logic signed [cwc_pkg::CLASS_W-1:0] req_land_value,
   input  logic req_is_missing,
   input  logic [cwc_pkg::CELL_W-1:0] req_query_cell,
   input  logic [cwc_pkg::DIM_W-1:0] req_half_width_x,
   input  logic [cwc_pkg::DIM_W-1:0] req_half_width_y,
   input  cwc_pkg::cmd_type cmd,
   output cwc_pkg::sts_type sts,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic [cwc_pkg::CNT_W-1:0] rsp_window_count,
   output logic [cwc_pkg::STAT_W-1:0] rsp_status
);
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam int CNT_W = cwc_pkg::CNT_W;
   localparam int DW = cwc_pkg::DIM_W;
   localparam int CLW = cwc_pkg::CELL_W;
   localparam logic [12:0] MR = 13'(MAX_ROWS);
   localparam logic [12:0] MC = 13'(MAX_COLS);

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rd_ff;

   logic [DW-1:0] rowc_ff, colc_ff;
   logic [12:0] rows, cols;    // effective dims, up to MAX
   logic [12:0] ld_row_ff, ld_col_ff;
   logic [CNT_W-1:0] left_ff, above_ff;
   logic ready_ff, hit_ff;
   logic signed [cwc_pkg::CLASS_W-1:0] target_ff;

   always_comb begin
      rows = (rowc_ff == '0) ? 13'd1 : ({2'b0, rowc_ff} > MR) ? MR : {2'b0, rowc_ff};
      cols = (colc_ff == '0) ? 13'd1 : ({2'b0, colc_ff} > MC) ? MC : {2'b0, colc_ff};
   end

   // memory port
   logic rd_en, wr_en, rd_zero_ff, rd_zero;
   logic [12:0] rd_r1, rd_c1;    // lookup coordinates plus one
   logic [AW-1:0] rd_addr, wr_addr;
   logic [CNT_W-1:0] wr_data;
   logic [12:0] rr, rc;

   always_comb begin
      rr = rd_r1 - 13'd1;
      rc = rd_c1 - 13'd1;
      rd_zero = (rd_r1 == '0) || (rd_c1 == '0);
      rd_addr = {rr[RW-1:0], rc[CW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
         rd_zero_ff <= rd_zero;
      end
   end

   wire [CNT_W-1:0] rd_val = rd_zero_ff ? '0 : rd_ff;

   // load path
   logic [12:0] cur_row, cur_col;
   logic restart;
   assign restart = ready_ff || (ld_row_ff >= rows) || (ld_col_ff >= cols);
   assign cur_row = restart ? 13'd0 : ld_row_ff;
   assign cur_col = restart ? 13'd0 : ld_col_ff;

   // query path
   logic [CLW-1:0] cell_ff;
   logic [DW-1:0] kx_ff, ky_ff;
   logic [CLW-1:0] rem_ff;
   logic [12:0] qr_ff;
   logic [4:0] dstep_ff;
   logic err_ff;
   logic [cwc_pkg::STAT_W-1:0] stat_ff;
   logic [12:0] r0_ff, c0_ff, r1_ff, c1_ff;
   logic [CNT_W-1:0] acc_ff;
   logic [1:0] acc_sel_ff;
   logic [25:0] area;
   assign area = 26'(rows) * 26'(cols);

   // restoring division of the cell index by cols, one quotient bit a step
   logic [CLW+12:0] dtrial;
   assign dtrial = {13'd0, rem_ff} - ({20'd0, cols} << (5'd19 - dstep_ff));

   logic [13:0] r_plus, c_plus;
   logic [12:0] qc;
   assign qc = rem_ff[12:0];
   assign r_plus = {1'b0, qr_ff} + {3'b0, ky_ff};
   assign c_plus = {1'b0, qc} + {3'b0, kx_ff};

   always_comb begin
      rd_en = 1'b0;
      rd_r1 = '0;
      rd_c1 = '0;
      if (cmd.ld_start) begin
         rd_en = 1'b1;
         rd_r1 = cur_row;
         rd_c1 = cur_col + 13'd1;
      end else if (cmd.ld_diag) begin
         rd_en = 1'b1;
         rd_r1 = ld_row_ff;
         rd_c1 = ld_col_ff;
      end else if (cmd.q_rd) begin
         rd_en = 1'b1;
         case (cmd.q_sel)
            2'd0: begin rd_r1 = r1_ff + 13'd1; rd_c1 = c1_ff + 13'd1; end
            2'd1: begin rd_r1 = r0_ff; rd_c1 = c1_ff + 13'd1; end
            2'd2: begin rd_r1 = r1_ff + 13'd1; rd_c1 = c0_ff; end
            default: begin rd_r1 = r0_ff; rd_c1 = c0_ff; end
         endcase
      end
   end

   logic [CNT_W-1:0] s_val;
   assign s_val = {20'd0, hit_ff} + above_ff + ((ld_col_ff != '0) ? left_ff : '0) - rd_val;
   assign wr_en = cmd.ld_write;
   assign wr_addr = {ld_row_ff[RW-1:0], ld_col_ff[CW-1:0]};
   assign wr_data = s_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         rowc_ff <= 11'd1;
         colc_ff <= 11'd1;
         ld_row_ff <= '0;
         ld_col_ff <= '0;
         left_ff <= '0;
         ready_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write && (csr_index inside {cwc_pkg::REG_TARGET, cwc_pkg::REG_ROWS,
                                             cwc_pkg::REG_COLS})) begin
            case (csr_index)
               cwc_pkg::REG_TARGET: target_ff <= csr_data;
               cwc_pkg::REG_ROWS: rowc_ff <= csr_data[DW-1:0];
               cwc_pkg::REG_COLS: colc_ff <= csr_data[DW-1:0];
               default: ;
            endcase
            ld_row_ff <= '0;
            ld_col_ff <= '0;
            left_ff <= '0;
            ready_ff <= 1'b0;
         end
         if (cmd.ld_start) begin
            ld_row_ff <= cur_row;
            ld_col_ff <= cur_col;
            if (restart) ready_ff <= 1'b0;
            if (restart) left_ff <= '0;
         end
         if (cmd.ld_write) begin
            left_ff <= s_val;
            if (ld_col_ff + 13'd1 >= cols) begin
               ld_col_ff <= '0;
               left_ff <= '0;
               ld_row_ff <= ld_row_ff + 13'd1;
               if (ld_row_ff + 13'd1 >= rows) ready_ff <= 1'b1;
            end else begin
               ld_col_ff <= ld_col_ff + 13'd1;
            end
         end
         if (cmd.out_load) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_start) hit_ff <= !req_is_missing && (req_land_value == target_ff);
      if (cmd.ld_diag) above_ff <= rd_val;
      if (cmd.q_start) begin
         kx_ff <= req_half_width_x;
         ky_ff <= req_half_width_y;
         rem_ff <= req_query_cell;
         qr_ff <= '0;
         dstep_ff <= '0;
         acc_ff <= '0;
         acc_sel_ff <= '0;
         if (!ready_ff) begin err_ff <= 1'b1; stat_ff <= cwc_pkg::ST_NOTABLE; end
         else if ({2'b0, req_half_width_x} > cols || {2'b0, req_half_width_y} > rows) begin
            err_ff <= 1'b1; stat_ff <= cwc_pkg::ST_HALF;
         end else if ({6'b0, req_query_cell} >= area) begin
            err_ff <= 1'b1; stat_ff <= cwc_pkg::ST_RANGE;
         end else begin err_ff <= 1'b0; stat_ff <= cwc_pkg::ST_OK; end
      end
      if (cmd.div_step) begin
         dstep_ff <= dstep_ff + 5'd1;
         if (!dtrial[CLW+12]) begin
            rem_ff <= dtrial[CLW-1:0];
            qr_ff <= {qr_ff[11:0], 1'b1};
         end else begin
            qr_ff <= {qr_ff[11:0], 1'b0};
         end
      end
      if (sts.div_done && !cmd.q_rd) begin
         r0_ff <= (qr_ff > {2'b0, ky_ff}) ? qr_ff - {2'b0, ky_ff} : '0;
         c0_ff <= (qc > {2'b0, kx_ff}) ? qc - {2'b0, kx_ff} : '0;
         r1_ff <= (r_plus < {1'b0, rows} - 14'd1) ? r_plus[12:0] : rows - 13'd1;
         c1_ff <= (c_plus < {1'b0, cols} - 14'd1) ? c_plus[12:0] : cols - 13'd1;
      end
      if (cmd.q_acc) begin
         acc_sel_ff <= acc_sel_ff + 2'd1;
         if (acc_sel_ff == 2'd0 || acc_sel_ff == 2'd3) acc_ff <= acc_ff + rd_val;
         else acc_ff <= acc_ff - rd_val;
      end
      if (cmd.out_load) begin
         rsp_window_count <= err_ff ? '0 : acc_ff;
         rsp_status <= stat_ff;
      end
   end

   // corner bounds settle in the cycle after the last quotient bit
   assign sts.div_done = (dstep_ff == 5'd20);
   assign sts.q_err = err_ff;
   assign sts.out_full = rsp_valid && !rsp_ready;

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cwc_pkg::ST_OK |-> rsp_window_count == '0)
      else $error("nonzero count on error");
   a_wr_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ld_row_ff < rows && ld_col_ff < cols) else $error("write outside raster");
endmodule
